// ----- hw/rtl/imuoc_pkg.sv -----
package imuoc_pkg;

    localparam int SAMPW        = 16;
    localparam int Q4W          = 21;
    localparam int WIDE_W       = Q4W + 2;
    localparam int ONE_G_COUNTS = 65536 / 8;
    localparam int Q4_MAX       = 1048575;
    localparam int Q4_MIN       = -1048576;

    typedef logic signed [SAMPW-1:0]  sample_t;
    typedef logic signed [Q4W-1:0]    q4_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic done;
        logic busy;
    } cal_stat_t;

    function automatic q4_t sat_q4(input wide_t v);
        q4_t r;
        if (v > Q4_MAX) begin
            r = Q4W'(Q4_MAX);
        end else if (v < Q4_MIN) begin
            r = Q4W'(Q4_MIN);
        end else begin
            r = Q4W'(v);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/imu_offset_cal_moving_average.sv -----
// Six-axis IMU bias removal and moving-average filter. Each input beat carries
// one raw sample (accel and gyro xyz, signed 16-bit) plus two start flags in
// s_tuser; each beat yields exactly one output beat with the windowed means in
// Q.4 (y and z negated) and the two calibration busy flags in m_tuser. A start
// flag launches a bias calibration over CAL_SAMPLES beats (ignored while that
// calibration runs); the new offsets apply from the completing beat onward,
// with one g taken off accel z. The block takes one beat per clock through its
// 8-stage pipeline (calibration sum, offset reciprocal multiply, offset
// correction, window cell chain, mean reciprocal multiply); it stalls only
// when the output side holds back a full pipeline.
// The window cells are cleared by reset, so no start-up pass is needed.
module imu_offset_cal_moving_average import imuoc_pkg::*; #(
    parameter int ACC_WINDOW  = 8,
    parameter int GYRO_WINDOW = 8,
    parameter int CAL_SAMPLES = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
    input  logic [1:0]   s_tuser,   // start_acc_cal, start_gyro_cal
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // acc_out_x/y/z, gyro_out_x/y/z, zero fill
    output logic [1:0]   m_tuser    // acc_cal_busy, gyro_cal_busy
);

    localparam int NSTG = 8;
    localparam int CL   = $clog2(CAL_SAMPLES);
    localparam int CSW  = SAMPW + 1 + CL;
    localparam int CXW  = CSW + 3;
    localparam int ASW  = Q4W + $clog2(ACC_WINDOW);
    localparam int GSW  = Q4W + $clog2(GYRO_WINDOW);
    localparam int AXW  = ASW - 1;
    localparam int GXW  = GSW - 1;

    // handshake chain
    logic [NSTG:1]   vld_reg;
    logic [NSTG:0]   vin;
    logic [NSTG+1:1] rdy;
    logic            s_accept;

    always_comb begin
        vin            = {vld_reg, s_tvalid};
        rdy[NSTG + 1]  = m_tready;
        for (int i = NSTG; i >= 1; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[1];
    assign s_accept = s_tvalid && rdy[1];
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vin[i-1];
                end
            end
        end
    end

    // stage 1: calibration accumulate
    sample_t                in_smp   [6];
    sample_t                acc_in   [3];
    sample_t                gyro_in  [3];
    logic signed [CSW-1:0]  acc_sum1 [3];
    logic signed [CSW-1:0]  gyro_sum1 [3];
    cal_stat_t              acc_st1;
    cal_stat_t              gyro_st1;
    sample_t                smp_reg  [1:4][6];

    always_comb begin
        for (int l = 0; l < 6; l++) begin
            in_smp[l] = s_tdata[SAMPW*l +: SAMPW];
        end
        for (int a = 0; a < 3; a++) begin
            acc_in[a]  = in_smp[a];
            gyro_in[a] = in_smp[3+a];
        end
    end

    imuoc_cal #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .Z_BIAS      (ONE_G_COUNTS)
    ) u_acc_cal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (rdy[1]),
        .upd     (s_accept),
        .start   (s_tuser[0]),
        .sample  (acc_in),
        .sum_q   (acc_sum1),
        .stat_q  (acc_st1)
    );

    imuoc_cal #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .Z_BIAS      (0)
    ) u_gyro_cal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (rdy[1]),
        .upd     (s_accept),
        .start   (s_tuser[1]),
        .sample  (gyro_in),
        .sum_q   (gyro_sum1),
        .stat_q  (gyro_st1)
    );

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            smp_reg[1] <= in_smp;
        end
        for (int i = 2; i <= 4; i++) begin
            if (rdy[i]) begin
                smp_reg[i] <= smp_reg[i-1];
            end
        end
    end

    // busy flags ride along, {gyro, acc}
    logic [1:0] busy_reg [2:NSTG];

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            busy_reg[2] <= {gyro_st1.busy, acc_st1.busy};
        end
        for (int i = 3; i <= NSTG; i++) begin
            if (rdy[i]) begin
                busy_reg[i] <= busy_reg[i-1];
            end
        end
    end

    // stage 2: magnitude of the finished sums; gyro offsets keep 4 fraction bits
    logic [CXW-1:0] mag_next [6];
    logic           neg_next [6];
    logic [CXW-1:0] mag2_reg [6];
    logic           neg2_reg [6];
    logic [1:0]     done2_reg;

    always_comb begin
        logic signed [CSW-1:0] abs_v;
        for (int a = 0; a < 3; a++) begin
            abs_v         = acc_sum1[a][CSW-1] ? -acc_sum1[a] : acc_sum1[a];
            mag_next[a]   = CXW'(abs_v);
            neg_next[a]   = acc_sum1[a][CSW-1];
            abs_v         = gyro_sum1[a][CSW-1] ? -gyro_sum1[a] : gyro_sum1[a];
            mag_next[3+a] = CXW'(abs_v) << 4;
            neg_next[3+a] = gyro_sum1[a][CSW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            mag2_reg  <= mag_next;
            neg2_reg  <= neg_next;
            done2_reg <= {gyro_st1.done, acc_st1.done};
        end
    end

    // stage 3: divide by the calibration length
    logic [CXW-1:0] q3       [6];
    logic           neg3_reg [6];
    logic [1:0]     done3_reg;

    for (genvar l = 0; l < 6; l++) begin : g_cal_div
        imuoc_recip_div #(
            .XW  (CXW),
            .DIV (CAL_SAMPLES)
        ) u_div (
            .aclk (aclk),
            .en   (rdy[3]),
            .x    (mag2_reg[l]),
            .q    (q3[l])
        );
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            neg3_reg  <= neg2_reg;
            done3_reg <= done2_reg;
        end
    end

    // stage 4: latch new offsets in sample order
    q4_t off_new      [6];
    q4_t acc_off_reg  [3];
    q4_t gyro_off_reg [3];

    always_comb begin
        q4_t mag_v;
        for (int l = 0; l < 6; l++) begin
            mag_v      = Q4W'(q3[l]);
            off_new[l] = neg3_reg[l] ? -mag_v : mag_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                acc_off_reg[a]  <= '0;
                gyro_off_reg[a] <= '0;
            end
        end else if (rdy[4] && vld_reg[3]) begin
            for (int a = 0; a < 3; a++) begin
                if (done3_reg[0]) begin
                    acc_off_reg[a] <= off_new[a];
                end
                if (done3_reg[1]) begin
                    gyro_off_reg[a] <= off_new[3+a];
                end
            end
        end
    end

    // stage 5: remove offsets, saturate to Q.4
    q4_t acc_cor_next  [3];
    q4_t gyro_cor_next [3];
    q4_t acc_cor_reg   [3];
    q4_t gyro_cor_reg  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc_cor_next[a]  = sat_q4((WIDE_W'(smp_reg[4][a]) <<< 4)
                                      - (WIDE_W'(acc_off_reg[a]) <<< 4));
            gyro_cor_next[a] = sat_q4((WIDE_W'(smp_reg[4][3+a]) <<< 4)
                                      - WIDE_W'(gyro_off_reg[a]));
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            acc_cor_reg  <= acc_cor_next;
            gyro_cor_reg <= gyro_cor_next;
        end
    end

    // stage 6: window cell chains with running sums
    logic signed [ASW-1:0] acc_wsum  [3];
    logic signed [GSW-1:0] gyro_wsum [3];
    logic                  win_shift;

    assign win_shift = rdy[6] && vld_reg[5];

    imuoc_window #(
        .DEPTH (ACC_WINDOW)
    ) u_acc_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (win_shift),
        .din     (acc_cor_reg),
        .sum     (acc_wsum)
    );

    imuoc_window #(
        .DEPTH (GYRO_WINDOW)
    ) u_gyro_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (win_shift),
        .din     (gyro_cor_reg),
        .sum     (gyro_wsum)
    );

    // stage 7: floor mean; a negative sum divides as its complement
    logic [AXW-1:0] acc_wx    [3];
    logic [GXW-1:0] gyro_wx   [3];
    logic [AXW-1:0] acc_q7    [3];
    logic [GXW-1:0] gyro_q7   [3];
    logic           neg7_reg  [6];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc_wx[a]  = AXW'(acc_wsum[a][ASW-1] ? ~acc_wsum[a] : acc_wsum[a]);
            gyro_wx[a] = GXW'(gyro_wsum[a][GSW-1] ? ~gyro_wsum[a] : gyro_wsum[a]);
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_win_div
        imuoc_recip_div #(
            .XW  (AXW),
            .DIV (ACC_WINDOW)
        ) u_acc_div (
            .aclk (aclk),
            .en   (rdy[7]),
            .x    (acc_wx[a]),
            .q    (acc_q7[a])
        );

        imuoc_recip_div #(
            .XW  (GXW),
            .DIV (GYRO_WINDOW)
        ) u_gyro_div (
            .aclk (aclk),
            .en   (rdy[7]),
            .x    (gyro_wx[a]),
            .q    (gyro_q7[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            for (int a = 0; a < 3; a++) begin
                neg7_reg[a]   <= acc_wsum[a][ASW-1];
                neg7_reg[3+a] <= gyro_wsum[a][GSW-1];
            end
        end
    end

    // stage 8: restore sign, negate y and z, output register
    wide_t qe       [6];
    q4_t   out_next [6];
    q4_t   out_reg  [6];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            qe[a]   = $signed(WIDE_W'(acc_q7[a]));
            qe[3+a] = $signed(WIDE_W'(gyro_q7[a]));
        end
        for (int l = 0; l < 6; l++) begin
            if (l == 0 || l == 3) begin
                out_next[l] = neg7_reg[l] ? Q4W'(-qe[l] - 1) : Q4W'(qe[l]);
            end else begin
                // negated floor mean of a negative sum is the quotient plus one
                out_next[l] = neg7_reg[l] ? sat_q4(qe[l] + 1) : Q4W'(-qe[l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[8]) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int l = 0; l < 6; l++) begin
            m_tdata[Q4W*l +: Q4W] = out_reg[l];
        end
    end

    assign m_tuser = busy_reg[NSTG];

endmodule

// ----- hw/rtl/imuoc_recip_div.sv -----
module imuoc_recip_div #(
    parameter int XW  = 26,
    parameter int DIV = 8
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [XW-1:0] x,
    output logic [XW-1:0] q
);

    // floor(x / DIV) for x < 2**XW by a rounded-up reciprocal
    localparam int SHIFT = XW + $clog2(DIV);
    localparam int MW    = XW + 2;
    localparam int PW    = XW + MW;
    localparam longint unsigned POW = 64'd1 << SHIFT;
    localparam logic [MW-1:0] RECIP = MW'((POW + 64'(DIV) - 64'd1) / 64'(DIV));

    logic [PW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(x) * PW'(RECIP);
        end
    end

    assign q = XW'(prod_reg >> SHIFT);

endmodule

// ----- hw/rtl/imuoc_cal.sv -----
module imuoc_cal import imuoc_pkg::*; #(
    parameter int CAL_SAMPLES = 256,
    parameter int Z_BIAS      = 0,
    localparam int SUM_W      = SAMPW + 1 + $clog2(CAL_SAMPLES)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    upd,
    input  logic                    start,
    input  sample_t                 sample [3],
    output logic signed [SUM_W-1:0] sum_q  [3],
    output cal_stat_t               stat_q
);

    localparam int CNTW = $clog2(CAL_SAMPLES);

    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic signed [SAMPW:0]   term     [3];
    logic [CNTW-1:0]         cnt_reg;
    logic [CNTW-1:0]         cnt_cur;
    logic                    act_reg;
    logic                    act_cur;
    logic                    done;

    always_comb begin
        act_cur = act_reg || start;
        cnt_cur = act_reg ? cnt_reg : '0;
        done    = act_cur && (cnt_cur == CNTW'(CAL_SAMPLES - 1));
        for (int a = 0; a < 3; a++) begin
            term[a] = (SAMPW + 1)'(sample[a]);
        end
        // take Z_BIAS (one g for the accel instance) off the vertical axis before summing
        term[2] = term[2] - (SAMPW + 1)'(Z_BIAS);
        for (int a = 0; a < 3; a++) begin
            sum_next[a] = (act_reg ? sum_reg[a] : '0) + SUM_W'(term[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (upd && act_cur) begin
            act_reg <= !done;
            cnt_reg <= done ? '0 : cnt_cur + 1'b1;
        end
    end

    // sums need no reset: an idle run starts from zero
    always_ff @(posedge aclk) begin
        if (upd && act_cur) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_q       <= sum_next;
            stat_q.done <= done;
            stat_q.busy <= act_cur && !done;
        end
    end

endmodule

// ----- hw/rtl/imuoc_win_cell.sv -----
module imuoc_win_cell import imuoc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic shift,
    input  q4_t  d [3],
    output q4_t  q [3]
);

    q4_t val_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                val_reg[a] <= '0;
            end
        end else if (shift) begin
            val_reg <= d;
        end
    end

    assign q = val_reg;

endmodule

// ----- hw/rtl/imuoc_window.sv -----
module imuoc_window import imuoc_pkg::*; #(
    parameter int DEPTH  = 8,
    localparam int SUM_W = Q4W + $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    shift,
    input  q4_t                     din [3],
    output logic signed [SUM_W-1:0] sum [3]
);

    q4_t                     tap      [DEPTH][3];
    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [SUM_W-1:0] sum_next [3];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            imuoc_win_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (shift),
                .d       (din),
                .q       (tap[0])
            );
        end else begin : g_body
            imuoc_win_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (shift),
                .d       (tap[i-1]),
                .q       (tap[i])
            );
        end
    end

    // add the new sample, drop the one leaving the tail cell
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum_next[a] = sum_reg[a] + SUM_W'(din[a]) - SUM_W'(tap[DEPTH-1][a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                sum_reg[a] <= '0;
            end
        end else if (shift) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import imuoc_pkg::*;

    localparam int ACC_WIN      = 8;
    localparam int GYR_WIN      = 8;
    localparam int CAL_LEN      = 256;
    localparam int ITEMS        = 1700;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        sample_t acc [3];
        sample_t gyr [3];
        logic    start_acc;
        logic    start_gyr;
    } imu_sample_t;

    typedef struct {
        q4_t  acc_mean [3];
        q4_t  gyr_mean [3];
        logic acc_busy;
        logic gyr_busy;
    } filter_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    imu_sample_t pending_samples[$];
    filter_out_t expected_means[$];

    int unsigned err_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned recv_cnt = 0;
    int unsigned total_items = 0;
    int unsigned cycle_cnt = 0;

    // predictor state
    longint acc_ofs [3] = '{0, 0, 0};
    longint gyr_ofs [3] = '{0, 0, 0};
    longint acc_cal_sum [3] = '{0, 0, 0};
    longint gyr_cal_sum [3] = '{0, 0, 0};
    int     acc_cal_cnt = 0;
    int     gyr_cal_cnt = 0;
    bit     acc_cal_on = 1'b0;
    bit     gyr_cal_on = 1'b0;
    longint acc_win [3][ACC_WIN];
    longint gyr_win [3][GYR_WIN];
    longint acc_win_sum [3] = '{0, 0, 0};
    longint gyr_win_sum [3] = '{0, 0, 0};
    int     acc_widx = 0;
    int     gyr_widx = 0;

    imu_offset_cal_moving_average #(
        .ACC_WINDOW  (ACC_WIN),
        .GYRO_WINDOW (GYR_WIN),
        .CAL_SAMPLES (CAL_LEN)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
        .s_tuser  (s_tuser),   // start_acc_cal, start_gyro_cal
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // acc_out_x/y/z, gyro_out_x/y/z, zero fill
        .m_tuser  (m_tuser)    // acc_cal_busy, gyro_cal_busy
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint clamp_q4(longint v);
        if (v > Q4_MAX) return Q4_MAX;
        if (v < Q4_MIN) return Q4_MIN;
        return v;
    endfunction

    function automatic longint floor_mean(longint s, longint n);
        longint q;
        q = s / n;
        if ((s % n) != 0 && s < 0) q = q - 1;
        return q;
    endfunction

    function automatic filter_out_t filter_sample(imu_sample_t s);
        filter_out_t r;
        longint a, g, am, gm;
        if (!acc_cal_on && s.start_acc) begin
            acc_cal_on  = 1'b1;
            acc_cal_cnt = 0;
            acc_cal_sum = '{0, 0, 0};
        end
        if (!gyr_cal_on && s.start_gyr) begin
            gyr_cal_on  = 1'b1;
            gyr_cal_cnt = 0;
            gyr_cal_sum = '{0, 0, 0};
        end
        if (acc_cal_on) begin
            acc_cal_cnt++;
            for (int i = 0; i < 3; i++) begin
                acc_cal_sum[i] += longint'(s.acc[i]) - ((i == 2) ? ONE_G_COUNTS : 0);
            end
            if (acc_cal_cnt >= CAL_LEN) begin
                for (int i = 0; i < 3; i++) begin
                    acc_ofs[i]     = acc_cal_sum[i] / CAL_LEN;
                    acc_cal_sum[i] = 0;
                end
                acc_cal_cnt = 0;
                acc_cal_on  = 1'b0;
            end
        end
        if (gyr_cal_on) begin
            gyr_cal_cnt++;
            for (int i = 0; i < 3; i++) gyr_cal_sum[i] += longint'(s.gyr[i]);
            if (gyr_cal_cnt >= CAL_LEN) begin
                // gyro offset keeps four fraction bits
                for (int i = 0; i < 3; i++) begin
                    gyr_ofs[i]     = (gyr_cal_sum[i] * 16) / CAL_LEN;
                    gyr_cal_sum[i] = 0;
                end
                gyr_cal_cnt = 0;
                gyr_cal_on  = 1'b0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            a = clamp_q4(longint'(s.acc[i]) * 16 - acc_ofs[i] * 16);
            g = clamp_q4(longint'(s.gyr[i]) * 16 - gyr_ofs[i]);
            acc_win_sum[i] += a - acc_win[i][acc_widx];
            acc_win[i][acc_widx] = a;
            gyr_win_sum[i] += g - gyr_win[i][gyr_widx];
            gyr_win[i][gyr_widx] = g;
        end
        acc_widx = (acc_widx + 1 >= ACC_WIN) ? 0 : acc_widx + 1;
        gyr_widx = (gyr_widx + 1 >= GYR_WIN) ? 0 : gyr_widx + 1;
        for (int i = 0; i < 3; i++) begin
            am = floor_mean(acc_win_sum[i], ACC_WIN);
            gm = floor_mean(gyr_win_sum[i], GYR_WIN);
            if (i != 0) begin
                am = clamp_q4(-am);
                gm = clamp_q4(-gm);
            end
            r.acc_mean[i] = q4_t'(am);
            r.gyr_mean[i] = q4_t'(gm);
        end
        r.acc_busy = acc_cal_on;
        r.gyr_busy = gyr_cal_on;
        return r;
    endfunction

    function automatic sample_t pick_value(int unsigned style, int base);
        int v;
        case (style)
            0: begin
                v = int'(sample_t'($urandom));
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: begin
                v = base + int'($urandom_range(0, 128)) - 64;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
        endcase
        return sample_t'(v);
    endfunction

    task automatic add_sample(int unsigned style, int acc_base[3], int gyr_base[3],
                              logic sa, logic sg);
        imu_sample_t s;
        for (int i = 0; i < 3; i++) begin
            s.acc[i] = pick_value(style, acc_base[i]);
            s.gyr[i] = pick_value(style, gyr_base[i]);
        end
        s.start_acc = sa;
        s.start_gyr = sg;
        pending_samples.push_back(s);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d want %0d", recv_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic fill_samples();
        int acc_base [3];
        int gyr_base [3];
        int fixed_vals [4] = '{0, 32767, -32768, -1};
        int unsigned kind, len, style;
        bit cal_acc, cal_gyr, first;
        logic sa, sg;
        // directed: extremes, window fill, both starts, restart while running
        for (int k = 0; k < 4; k++) begin
            acc_base = '{fixed_vals[k], fixed_vals[k], fixed_vals[k]};
            gyr_base = '{fixed_vals[k], fixed_vals[k], fixed_vals[k]};
            add_sample(2'd3, acc_base, gyr_base, 1'b0, 1'b0);
            pending_samples[$].acc = '{sample_t'(fixed_vals[k]), sample_t'(fixed_vals[k]),
                                       sample_t'(fixed_vals[k])};
            pending_samples[$].gyr = '{sample_t'(fixed_vals[3-k]), sample_t'(fixed_vals[3-k]),
                                       sample_t'(fixed_vals[3-k])};
        end
        for (int k = 0; k < 10; k++) add_sample(1, acc_base, gyr_base, 1'b0, 1'b0);
        add_sample(1, acc_base, gyr_base, 1'b1, 1'b0);
        add_sample(1, acc_base, gyr_base, 1'b0, 1'b1);
        add_sample(1, acc_base, gyr_base, 1'b1, 1'b1);
        for (int k = 0; k < 5; k++) add_sample(0, acc_base, gyr_base, 1'b1, 1'b1);
        // random: calibration runs with steady data, mixed with noise
        first = 1'b1;
        while (pending_samples.size() < ITEMS) begin
            kind    = first ? 3 : $urandom_range(0, 4);
            cal_acc = (kind == 1 || kind == 3);
            cal_gyr = (kind == 2 || kind == 3);
            for (int i = 0; i < 3; i++) begin
                acc_base[i] = $urandom_range(0, 1) ? fixed_vals[$urandom_range(0, 3)]
                                                   : int'(sample_t'($urandom));
                gyr_base[i] = $urandom_range(0, 1) ? fixed_vals[$urandom_range(0, 3)]
                                                   : int'(sample_t'($urandom));
                if (first) begin
                    // large negative bias, so that a later high accel z saturates
                    acc_base[i] = -32768;
                    gyr_base[i] = -32768;
                end
            end
            first = 1'b0;
            len = (cal_acc || cal_gyr) ? CAL_LEN + $urandom_range(4, 60)
                                       : $urandom_range(10, 80);
            for (int n = 0; n < len; n++) begin
                if ((cal_acc || cal_gyr) && n < CAL_LEN) begin
                    style = ($urandom_range(0, 7) == 0) ? 0 : 2;
                end else begin
                    style = $urandom_range(0, 2);
                end
                sa = (n == 0 && cal_acc) || ($urandom_range(0, 63) == 0);
                sg = (n == 0 && cal_gyr) || ($urandom_range(0, 63) == 0);
                add_sample(style, acc_base, gyr_base, sa, sg);
            end
        end
    endtask

    // input side
    imu_sample_t drv_sample;
    int unsigned send_gap = 0;
    bit          send_burst = 1'b0;

    always @(posedge aclk) begin
        logic [95:0] d;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_means.push_back(filter_sample(drv_sample));
                sent_cnt <= sent_cnt + 1;
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat until taken
            end else if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_samples.size() != 0) begin
                drv_sample = pending_samples.pop_front();
                for (int i = 0; i < 3; i++) begin
                    d[i*SAMPW +: SAMPW]     = drv_sample.acc[i];
                    d[(3+i)*SAMPW +: SAMPW] = drv_sample.gyr[i];
                end
                s_tdata  <= d;
                s_tuser  <= {drv_sample.start_gyr, drv_sample.start_acc};
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                send_gap <= send_burst ? 0 : $urandom_range(0, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long output hold-off, so that the pipeline fills and stalls the input
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    wire         hold_on = (hold_left != 0);

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output side
    int unsigned stall_left = 0;
    bit          recv_burst = 1'b0;

    always @(posedge aclk) begin
        filter_out_t want;
        q4_t         got;
        int unsigned next_stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            next_stall = (stall_left != 0) ? stall_left - 1 : 0;
            if (m_tvalid && m_tready) begin
                recv_cnt <= recv_cnt + 1;
                if (expected_means.size() == 0) begin
                    report_mismatch("beat with nothing expected", 0, 0);
                end else begin
                    want = expected_means.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        got = q4_t'(m_tdata[i*Q4W +: Q4W]);
                        if (got != want.acc_mean[i])
                            report_mismatch($sformatf("acc_out axis %0d", i), got,
                                            want.acc_mean[i]);
                        got = q4_t'(m_tdata[(3+i)*Q4W +: Q4W]);
                        if (got != want.gyr_mean[i])
                            report_mismatch($sformatf("gyro_out axis %0d", i), got,
                                            want.gyr_mean[i]);
                    end
                    if (m_tuser[0] !== want.acc_busy)
                        report_mismatch("acc_cal_busy", m_tuser[0], want.acc_busy);
                    if (m_tuser[1] !== want.gyr_busy)
                        report_mismatch("gyro_cal_busy", m_tuser[1], want.gyr_busy);
                    if (m_tdata[127:6*Q4W] !== '0)
                        report_mismatch("zero fill", m_tdata[127:6*Q4W], 0);
                end
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                next_stall = recv_burst ? 0 : $urandom_range(0, 4);
            end
            stall_left <= next_stall;
            m_tready   <= !hold_on && (next_stall == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < ACC_WIN; j++) acc_win[i][j] = 0;
            for (int j = 0; j < GYR_WIN; j++) gyr_win[i][j] = 0;
        end
        fill_samples();
        total_items = pending_samples.size();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (sent_cnt < total_items || expected_means.size() != 0) @(posedge aclk);
        // let any stray beat show up
        repeat (24) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/imuoc_pkg.sv
hw/rtl/imuoc_recip_div.sv
hw/rtl/imuoc_cal.sv
hw/rtl/imuoc_win_cell.sv
hw/rtl/imuoc_window.sv
hw/rtl/imu_offset_cal_moving_average.sv
tb/testbench.sv
